>>> hw/rtl/gkpw_pkg.sv
// ----------------------------------------------------------------------------
// gkpw_pkg
// Shared types and constants for the gait key-point window classifier.
// ----------------------------------------------------------------------------
package gkpw_pkg;

    localparam int WINDOW_LEN_DEF = 15;
    localparam int SAMPLE_W       = 16;
    localparam int LIMIT_W        = 32;
    localparam int CFG_ADDR_W     = 2;
    localparam int CLASS_W        = 3;

    localparam logic [LIMIT_W-1:0] STILL_LIMIT_RST = 32'd4624220;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_STILL_LIMIT = 2'd0,
        CFG_ANGLE_LIMIT = 2'd1,
        CFG_RATE_LIMIT  = 2'd2
    } cfg_index_t;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NOT_READY = 3'd0,
        CLS_NONE      = 3'd1,
        CLS_ANGLE_MIN = 3'd2,
        CLS_RATE_PEAK = 3'd3,
        CLS_RATE_ZERO = 3'd4,
        CLS_STILL     = 3'd5
    } class_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_SUM,
        ST_SCAN,
        ST_CLASS,
        ST_DONE
    } state_t;

    // one window entry, held by one cell
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] angle;
        logic signed [SAMPLE_W-1:0] rate;
        logic                       still;
    } entry_t;

endpackage

>>> hw/rtl/gkpw_cell.sv
// ----------------------------------------------------------------------------
// gkpw_cell
// One window cell: holds an entry and takes its neighbor's entry on load.
// ----------------------------------------------------------------------------
module gkpw_cell
    import gkpw_pkg::*;
(
    input  logic   aclk,
    input  logic   load,
    input  entry_t entry_in,
    output entry_t entry_out
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = load ? entry_in : entry_reg;
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

>>> hw/rtl/gkpw_msq.sv
// ----------------------------------------------------------------------------
// gkpw_msq
// Squared acceleration magnitude: three registered squares and their sum.
// ----------------------------------------------------------------------------
module gkpw_msq
    import gkpw_pkg::*;
(
    input  logic                       aclk,
    input  logic                       en,
    input  logic signed [SAMPLE_W-1:0] acc_x,
    input  logic signed [SAMPLE_W-1:0] acc_y,
    input  logic signed [SAMPLE_W-1:0] acc_z,
    output logic        [LIMIT_W-1:0]  mag_sq
);

    localparam int PROD_W = 2 * SAMPLE_W;

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic [PROD_W-2:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [PROD_W-2:0] sq_x_next, sq_y_next, sq_z_next;

    always_comb begin
        prod_x    = PROD_W'(acc_x) * PROD_W'(acc_x);
        prod_y    = PROD_W'(acc_y) * PROD_W'(acc_y);
        prod_z    = PROD_W'(acc_z) * PROD_W'(acc_z);
        sq_x_next = en ? prod_x[PROD_W-2:0] : sq_x_reg;
        sq_y_next = en ? prod_y[PROD_W-2:0] : sq_y_reg;
        sq_z_next = en ? prod_z[PROD_W-2:0] : sq_z_reg;
    end

    always_ff @(posedge aclk) begin
        sq_x_reg <= sq_x_next;
        sq_y_reg <= sq_y_next;
        sq_z_reg <= sq_z_next;
    end

    // each square is at most 2^30, so the sum fits 32 bits
    assign mag_sq = {1'b0, sq_x_reg} + {1'b0, sq_y_reg} + {1'b0, sq_z_reg};

endmodule

>>> hw/rtl/gait_key_point_window_classifier.sv
// ----------------------------------------------------------------------------
// gait_key_point_window_classifier
// Sliding-window classifier of IMU samples for gait key points.
// ----------------------------------------------------------------------------
// Each accepted sample is shifted into a row of WINDOW_LEN cells and one
// class for the window's middle sample is returned per request. The first
// WINDOW_LEN-1 results are "not ready". While filling, a sample passes
// through ST_SQR, ST_SUM and ST_DONE before the next accept; once the window
// is full, ST_SCAN also rotates the ring of cells once past the single
// min/max comparator and ST_CLASS follows. A new sample is taken while the
// previous result still waits in the output register.
module gait_key_point_window_classifier
    import gkpw_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,   // acc_x, acc_y, acc_z, rate_x, angle_x
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // middle_class, zero fill
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LIMIT_W-1:0]    cfg_wdata
);

    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int MID   = WINDOW_LEN / 2;
    localparam int IN_W  = 5 * SAMPLE_W;

    function automatic logic crosses(input logic signed [SAMPLE_W-1:0] mid,
                                     input logic signed [SAMPLE_W-1:0] nb);
        logic signed [SAMPLE_W:0] ms;
        logic signed [SAMPLE_W:0] ns;
        logic        [SAMPLE_W:0] mm;
        logic        [SAMPLE_W:0] nm;
        logic                     opp;
        ms  = {mid[SAMPLE_W-1], mid};
        ns  = {nb[SAMPLE_W-1], nb};
        mm  = ms[SAMPLE_W] ? (SAMPLE_W+1)'(-ms) : ms;
        nm  = ns[SAMPLE_W] ? (SAMPLE_W+1)'(-ns) : ns;
        opp = (mid > 0 && nb < 0) || (mid < 0 && nb > 0);
        return opp && (mm < nm);
    endfunction

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0]         still_limit_reg;
    logic signed [SAMPLE_W-1:0] angle_limit_reg;
    logic signed [SAMPLE_W-1:0] rate_limit_reg;

    logic [IN_W-1:0]            sample_reg, sample_next;
    logic [CNT_W-1:0]           fill_cnt_reg, fill_cnt_next;
    logic [CNT_W-1:0]           still_cnt_reg, still_cnt_next;
    logic [CNT_W-1:0]           scan_cnt_reg, scan_cnt_next;
    logic signed [SAMPLE_W-1:0] amin_reg, amin_next;
    logic signed [SAMPLE_W-1:0] rmax_reg, rmax_next;
    class_t                     cls_reg, cls_next;
    logic                       m_tvalid_reg, m_tvalid_next;
    class_t                     m_class_reg, m_class_next;

    logic in_accept, out_free;
    logic cell_shift, cell_rotate, msq_en;
    logic scan_last;
    logic still_new;
    logic [LIMIT_W-1:0] mag_sq;
    entry_t new_entry;
    entry_t head;
    entry_t cell_q [WINDOW_LEN];
    entry_t cell_d [WINDOW_LEN];

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign scan_last = (scan_cnt_reg == CNT_W'(WINDOW_LEN - 1));
    assign head      = cell_q[0];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            still_limit_reg <= STILL_LIMIT_RST;
            angle_limit_reg <= '0;
            rate_limit_reg  <= '0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_STILL_LIMIT: still_limit_reg <= cfg_wdata;
                CFG_ANGLE_LIMIT: angle_limit_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_RATE_LIMIT:  rate_limit_reg  <= cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    gkpw_msq u_msq (
        .aclk   (aclk),
        .en     (msq_en),
        .acc_x  (sample_reg[SAMPLE_W-1:0]),
        .acc_y  (sample_reg[2*SAMPLE_W-1:SAMPLE_W]),
        .acc_z  (sample_reg[3*SAMPLE_W-1:2*SAMPLE_W]),
        .mag_sq (mag_sq)
    );

    assign still_new       = (mag_sq <= still_limit_reg);
    assign new_entry.rate  = sample_reg[4*SAMPLE_W-1:3*SAMPLE_W];
    assign new_entry.angle = sample_reg[5*SAMPLE_W-1:4*SAMPLE_W];
    assign new_entry.still = still_new;

    // shift: oldest leaves at cell 0, new sample enters at the end
    // rotate: cell 0 wraps to the end, WINDOW_LEN rotations restore the row
    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
        if (i == WINDOW_LEN - 1) begin : g_tail
            assign cell_d[i] = cell_shift ? new_entry : cell_q[0];
        end else begin : g_body
            assign cell_d[i] = cell_q[i+1];
        end
        gkpw_cell u_cell (
            .aclk      (aclk),
            .load      (cell_shift || cell_rotate),
            .entry_in  (cell_d[i]),
            .entry_out (cell_q[i])
        );
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_accept) state_next = ST_SQR;
            ST_SQR:   state_next = ST_SUM;
            ST_SUM: begin
                if (fill_cnt_reg >= CNT_W'(WINDOW_LEN - 1)) state_next = ST_SCAN;
                else                                        state_next = ST_DONE;
            end
            ST_SCAN:  if (scan_last) state_next = ST_CLASS;
            ST_CLASS: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready    = 1'b0;
        msq_en      = 1'b0;
        cell_shift  = 1'b0;
        cell_rotate = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready    = 1'b1;
            ST_SQR:  msq_en      = 1'b1;
            ST_SUM:  cell_shift  = 1'b1;
            ST_SCAN: cell_rotate = 1'b1;
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        sample_next    = in_accept ? s_tdata : sample_reg;
        fill_cnt_next  = fill_cnt_reg;
        still_cnt_next = still_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        amin_next      = amin_reg;
        rmax_next      = rmax_reg;
        cls_next       = cls_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_class_next   = m_class_reg;

        if (cell_shift) begin
            if (fill_cnt_reg == CNT_W'(WINDOW_LEN) && head.still
                    && still_cnt_reg != '0) begin
                still_cnt_next = still_cnt_reg - CNT_W'(1);
            end
            if (still_new) begin
                still_cnt_next = still_cnt_next + CNT_W'(1);
            end
            if (fill_cnt_reg != CNT_W'(WINDOW_LEN)) begin
                fill_cnt_next = fill_cnt_reg + CNT_W'(1);
            end
            cls_next      = CLS_NOT_READY;
            scan_cnt_next = '0;
        end

        if (cell_rotate) begin
            if (scan_cnt_reg == '0) begin
                amin_next = head.angle;
                rmax_next = head.rate;
            end else begin
                if (head.angle < amin_reg) amin_next = head.angle;
                if (head.rate > rmax_reg)  rmax_next = head.rate;
            end
            scan_cnt_next = scan_cnt_reg + CNT_W'(1);
        end

        if (state_reg == ST_CLASS) begin
            priority if (amin_reg == cell_q[MID].angle && amin_reg < angle_limit_reg) begin
                cls_next = CLS_ANGLE_MIN;
            end else if (rmax_reg == cell_q[MID].rate && rmax_reg > rate_limit_reg) begin
                cls_next = CLS_RATE_PEAK;
            end else if (still_cnt_reg > CNT_W'(WINDOW_LEN / 2)) begin
                cls_next = CLS_STILL;
            end else if (crosses(cell_q[MID].rate, cell_q[MID-1].rate)
                      || crosses(cell_q[MID].rate, cell_q[MID+1].rate)) begin
                cls_next = CLS_RATE_ZERO;
            end else begin
                cls_next = CLS_NONE;
            end
        end

        if (m_tready) m_tvalid_next = 1'b0;
        if (state_reg == ST_DONE && out_free) begin
            m_tvalid_next = 1'b1;
            m_class_next  = cls_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_cnt_reg  <= '0;
            still_cnt_reg <= '0;
            scan_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_cnt_reg  <= fill_cnt_next;
            still_cnt_reg <= still_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg  <= sample_next;
        amin_reg    <= amin_next;
        rmax_reg    <= rmax_next;
        cls_reg     <= cls_next;
        m_class_reg <= m_class_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_class_reg};

endmodule

>>> tb/gkpw_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gkpw_checker
// Scoreboard for the gait key-point window classifier.
// ----------------------------------------------------------------------------
// Mirrors the block's limit registers and sliding window from the observed
// register writes and accepted sample requests. It works out the middle
// class for each sample and compares it with the class that comes back.
module gkpw_checker
    import gkpw_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [79:0]           s_tdata,   // acc_x, acc_y, acc_z, rate_x, angle_x
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [7:0]            m_tdata,   // middle_class, zero fill
    input  logic                  cfg_wen,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [LIMIT_W-1:0]    cfg_wdata,
    output int                    mismatches,
    output int                    awaiting
);

    logic [LIMIT_W-1:0]         still_limit;
    logic signed [SAMPLE_W-1:0] angle_limit;
    logic signed [SAMPLE_W-1:0] rate_limit;

    logic signed [SAMPLE_W-1:0] angle_row [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] rate_row  [WINDOW_LEN];
    bit                         still_row [WINDOW_LEN];
    int                         fill_level;
    int                         still_total;
    int                         fault_total;
    class_t                     pending_classes [$];

    function automatic bit crosses_toward(input int center, input int side);
        return ((center > 0 && side < 0) || (center < 0 && side > 0)) &&
               ((center < 0 ? -center : center) < (side < 0 ? -side : side));
    endfunction

    task automatic shift_in_sample(input logic [79:0] d, output class_t cls);
        logic signed [SAMPLE_W-1:0] ax, ay, az, rate, angle, amin, rmax;
        longint                     mag_sq;
        bit                         still;
        int                         mid;
        ax     = d[15:0];
        ay     = d[31:16];
        az     = d[47:32];
        rate   = d[63:48];
        angle  = d[79:64];
        mid    = WINDOW_LEN / 2;
        mag_sq = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
               + longint'(az) * longint'(az);
        still  = mag_sq <= longint'(still_limit);

        // oldest entry drops out of the still count once the window is full
        if (fill_level >= WINDOW_LEN && still_row[0] && still_total > 0)
            still_total--;
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            angle_row[i] = angle_row[i + 1];
            rate_row[i]  = rate_row[i + 1];
            still_row[i] = still_row[i + 1];
        end
        angle_row[WINDOW_LEN - 1] = angle;
        rate_row[WINDOW_LEN - 1]  = rate;
        still_row[WINDOW_LEN - 1] = still;
        if (still)
            still_total++;
        if (fill_level < WINDOW_LEN)
            fill_level++;

        if (fill_level < WINDOW_LEN) begin
            cls = CLS_NOT_READY;
        end else begin
            amin = angle_row[0];
            rmax = rate_row[0];
            for (int i = 1; i < WINDOW_LEN; i++) begin
                if (angle_row[i] < amin)
                    amin = angle_row[i];
                if (rate_row[i] > rmax)
                    rmax = rate_row[i];
            end
            if (amin == angle_row[mid] && amin < angle_limit)
                cls = CLS_ANGLE_MIN;
            else if (rmax == rate_row[mid] && rmax > rate_limit)
                cls = CLS_RATE_PEAK;
            else if (still_total > WINDOW_LEN / 2)
                cls = CLS_STILL;
            else if (crosses_toward(rate_row[mid], rate_row[mid - 1]) ||
                     crosses_toward(rate_row[mid], rate_row[mid + 1]))
                cls = CLS_RATE_ZERO;
            else
                cls = CLS_NONE;
        end
    endtask

    always @(posedge aclk) begin
        class_t cls;
        class_t want;
        if (!aresetn) begin
            still_limit = STILL_LIMIT_RST;
            angle_limit = '0;
            rate_limit  = '0;
            fill_level  = 0;
            still_total = 0;
            fault_total = 0;
            pending_classes.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                shift_in_sample(s_tdata, cls);
                pending_classes.insert(pending_classes.size(), cls);
            end
            if (m_tvalid && m_tready) begin
                if (pending_classes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, m_tdata);
                    fault_total++;
                end else begin
                    want = pending_classes[0];
                    pending_classes.delete(0);
                    if (m_tdata !== {{(8 - CLASS_W){1'b0}}, want}) begin
                        $display("%0t: middle_class expected %0d (%s), actual %0d",
                                 $time, want, want.name(), m_tdata);
                        fault_total++;
                    end
                end
            end
            if (cfg_wen) begin
                case (cfg_addr)
                    CFG_STILL_LIMIT: still_limit = cfg_wdata;
                    CFG_ANGLE_LIMIT: angle_limit = cfg_wdata[SAMPLE_W-1:0];
                    CFG_RATE_LIMIT:  rate_limit  = cfg_wdata[SAMPLE_W-1:0];
                    default: ;
                endcase
            end
        end
        mismatches <= fault_total;
        awaiting   <= pending_classes.size();
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the gait key-point window classifier.
// ----------------------------------------------------------------------------
// Sends a hand-built sample sequence that walks every class, then random
// gait-like, extreme and noise samples under several limit settings, with
// random idle bursts on both streams. A separate checker scores the results.
module testbench;
    import gkpw_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 120;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [79:0]           s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_STILL_LIMIT;
    logic [LIMIT_W-1:0]    cfg_wdata = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [7:0]            m_tdata;

    int mismatches;
    int awaiting;
    bit source_idle_on = 1'b1;
    bit sink_idle_on   = 1'b1;
    int stall_left     = 0;
    int quiet_cycles   = 0;

    always #6 aclk = ~aclk;

    gait_key_point_window_classifier uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    gkpw_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wen    (cfg_wen),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // result-side backpressure in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic [79:0] pack_sample(input int ax, input int ay, input int az,
                                                input int rate, input int angle);
        return {16'(angle), 16'(rate), 16'(az), 16'(ay), 16'(ax)};
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0:       return -32768;
            1:       return -1;
            2:       return 0;
            3:       return 1;
            default: return 32767;
        endcase
    endfunction

    function automatic int near(input int center, input int spread);
        return center + int'($urandom_range(0, 2 * spread)) - spread;
    endfunction

    // walks not-ready, rate zero via older and newer neighbor, angle min and
    // rate peak with ties, none, and still majority at the reset limits
    function automatic logic [79:0] directed_sample(input int idx);
        int ax, ay, az, rate, angle;
        ax    = 0;
        ay    = 0;
        az    = 4096;
        rate  = 100;
        angle = 200;
        case (idx)
            0:  begin ax = -32768; ay = -32768; az = -32768; rate = -32768; angle = -32768; end
            1:  begin ax = 32767;  ay = 32767;  az = 32767;  rate = 32767;  angle = 32767;  end
            6:  rate = -20;
            7:  rate = 10;
            8:  angle = -1000;
            9:  rate = 5000;
            10: rate = 7;
            11: rate = -30;
            12: begin rate = -40; angle = -1000; end
            13: rate = 5000;
            default: if (idx >= 14) az = 2048;
        endcase
        return pack_sample(ax, ay, az, rate, angle);
    endfunction

    function automatic logic [79:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return pack_sample(near(0, 100), near(0, 100), near(2048, 150),
                               near(0, 8), near(0, 8));
        else if (pick < 66)
            return pack_sample(0, 0, (pick % 2) ? 2048 : ((pick % 3) ? 2049 : 0),
                               near(0, 8), near(0, 8));
        else if (pick < 85)
            return 80'({$urandom, $urandom, $urandom});
        else
            return pack_sample(extreme_value(), extreme_value(), extreme_value(),
                               extreme_value(), extreme_value());
    endfunction

    task automatic send_sample(input logic [79:0] d);
        if (source_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (awaiting != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 25; i++)
            send_sample(directed_sample(i));

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            case (p)
                0: begin
                    write_reg(CFG_STILL_LIMIT, '0);
                    write_reg(CFG_ANGLE_LIMIT, {16'($urandom), 16'h8000});
                    write_reg(CFG_RATE_LIMIT, {16'($urandom), 16'h7fff});
                end
                1: begin
                    write_reg(CFG_STILL_LIMIT, 32'hc000_0000);
                    write_reg(CFG_ANGLE_LIMIT, {16'($urandom), 16'h7fff});
                    write_reg(CFG_RATE_LIMIT, {16'($urandom), 16'h8000});
                    write_reg(CFG_UNMAPPED, $urandom);
                end
                2: begin
                    write_reg(CFG_STILL_LIMIT, 32'd4194304);
                    write_reg(CFG_ANGLE_LIMIT, '0);
                    write_reg(CFG_RATE_LIMIT, '0);
                end
                default: begin
                    write_reg(CFG_STILL_LIMIT, $urandom_range(3800000, 4800000));
                    write_reg(CFG_ANGLE_LIMIT, 32'(near(0, 8)));
                    write_reg(CFG_RATE_LIMIT, 32'(near(0, 8)));
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0) begin
                    source_idle_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
                    sink_idle_on   = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
                end
                if (p == 0 && n == 60)
                    drain_results();
                send_sample(random_sample());
            end
        end

        drain_results();
        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
